// ----- sv/ihc_pkg.sv -----
// ihc_pkg: shared types, codes and helpers of the ipv4 ingress header classifier
// no dependencies; imported by every module of the block
`default_nettype none

package ihc_pkg;

  // verdict codes
  typedef enum logic [3:0] {
    V_DROP      = 4'd0,
    V_LOCAL_TTL = 4'd1,
    V_ICMP      = 4'd2,
    V_TCP       = 4'd3,
    V_UDP       = 4'd4,
    V_OSPF      = 4'd5,
    V_UNREACH   = 4'd6,
    V_FORWARD   = 4'd7,
    V_FWD_TTL   = 4'd8
  } verdict_t;

  // error cause codes, in check order
  typedef enum logic [2:0] {
    E_NONE     = 3'd0,
    E_VERSION  = 3'd1,
    E_HLEN     = 3'd2,
    E_TOTLEN   = 3'd3,
    E_CHECKSUM = 3'd4,
    E_FRAGMENT = 3'd5
  } err_t;

  // configuration register indexes
  localparam logic [1:0] CFG_IFACE_ADDR = 2'd0;
  localparam logic [1:0] CFG_SPF_ADDR   = 2'd1;
  localparam logic [1:0] CFG_MIN_LEN    = 2'd2;
  localparam logic [1:0] CFG_MAX_LEN    = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // header constants
  localparam logic [3:0]  IPV4_VERSION = 4'd4;
  localparam logic [3:0]  COUNT_MAX    = 4'hF;
  localparam logic [15:0] FLAGS_DF     = 16'h4000;
  localparam logic [15:0] FLAGS_NONE   = 16'h0000;
  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  PROTO_OSPF   = 8'd89;

  // word positions inside the header
  localparam logic [3:0] POS_LEN   = 4'd0;
  localparam logic [3:0] POS_FRAG  = 4'd1;
  localparam logic [3:0] POS_TTL   = 4'd2;
  localparam logic [3:0] POS_DEST  = 4'd4;

  // configuration register set
  typedef struct packed {
    logic [31:0] iface_addr;
    logic [31:0] spf_addr;
    logic [15:0] min_len;
    logic [15:0] max_len;
  } cfg_t;

  // one collected header, handed from front to back
  typedef struct packed {
    logic [7:0]  ver_hlen;
    logic [15:0] total_len;
    logic [15:0] flags_off;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] dest;
    logic [15:0] recv_chk;
    logic [15:0] sum;
    logic [3:0]  count;
  } hdr_rec_t;

  // two-step ones-complement fold of a sum of up to three 16-bit terms
  function automatic logic [15:0] fold16(input logic [17:0] x);
    logic [16:0] t;
    logic [16:0] r;
    t = {1'b0, x[15:0]} + {15'd0, x[17:16]};
    r = {1'b0, t[15:0]} + {16'd0, t[16]};
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/ihc_if.sv -----
// ihc_if: valid/ready channel interfaces for header words and verdicts
// no dependencies
`default_nettype none

interface ihc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] header_word;
  logic        last_word;

  modport source (output valid, output header_word, output last_word, input ready);
  modport sink   (input valid, input header_word, input last_word, output ready);
endinterface

interface ihc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [2:0]  error_cause;
  logic [31:0] dest_addr;
  logic [7:0]  new_ttl;
  logic [15:0] new_checksum;
  logic [15:0] payload_length;

  modport source (output valid, output verdict, output error_cause, output dest_addr,
                  output new_ttl, output new_checksum, output payload_length,
                  input ready);
  modport sink   (input valid, input verdict, input error_cause, input dest_addr,
                  input new_ttl, input new_checksum, input payload_length,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/ihc_front.sv -----
// ihc_front: takes header words, folds the running sum and captures fields
// depends on ihc_pkg and ihc_in_if; pushes one header record per last word
`default_nettype none

module ihc_front
  import ihc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  ihc_in_if.sink     in_ch,
  input  wire logic  q_full,
  output logic       push,
  output hdr_rec_t   rec
);

  logic [3:0]  count_r;
  logic [15:0] sum_r;
  logic [7:0]  ver_hlen_r;
  logic [15:0] total_len_r;
  logic [15:0] flags_off_r;
  logic [7:0]  ttl_r;
  logic [7:0]  proto_r;
  logic [31:0] dest_r;
  logic [15:0] recv_chk_r;

  logic [3:0]  count_nxt;
  logic [15:0] sum_nxt;
  logic [7:0]  ver_hlen_nxt;
  logic [15:0] total_len_nxt;
  logic [15:0] flags_off_nxt;
  logic [7:0]  ttl_nxt;
  logic [7:0]  proto_nxt;
  logic [31:0] dest_nxt;
  logic [15:0] recv_chk_nxt;
  logic        accept;
  logic [31:0] w;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign w           = in_ch.header_word;

  // capture by word position, sum everything but the ttl/proto/checksum word
  always_comb begin
    sum_nxt       = sum_r;
    ver_hlen_nxt  = ver_hlen_r;
    total_len_nxt = total_len_r;
    flags_off_nxt = flags_off_r;
    ttl_nxt       = ttl_r;
    proto_nxt     = proto_r;
    dest_nxt      = dest_r;
    recv_chk_nxt  = recv_chk_r;
    if (count_r == POS_TTL) begin
      ttl_nxt      = w[31:24];
      proto_nxt    = w[23:16];
      recv_chk_nxt = w[15:0];
    end else begin
      sum_nxt = fold16({2'b00, sum_r} + {2'b00, w[31:16]} + {2'b00, w[15:0]});
      if (count_r == POS_LEN) begin
        ver_hlen_nxt  = w[31:24];
        total_len_nxt = w[15:0];
      end else if (count_r == POS_FRAG) begin
        flags_off_nxt = w[15:0];
      end else if (count_r == POS_DEST) begin
        dest_nxt = w;
      end
    end
    count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + 4'd1;
  end

  // record of the finished header
  assign push = accept && in_ch.last_word;
  always_comb begin
    rec.ver_hlen  = ver_hlen_nxt;
    rec.total_len = total_len_nxt;
    rec.flags_off = flags_off_nxt;
    rec.ttl       = ttl_nxt;
    rec.proto     = proto_nxt;
    rec.dest      = dest_nxt;
    rec.recv_chk  = recv_chk_nxt;
    rec.sum       = sum_nxt;
    rec.count     = count_nxt;
  end

  // collection state, cleared after every last word
  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      count_r     <= '0;
      sum_r       <= '0;
      ver_hlen_r  <= '0;
      total_len_r <= '0;
      flags_off_r <= '0;
      ttl_r       <= '0;
      proto_r     <= '0;
      dest_r      <= '0;
      recv_chk_r  <= '0;
    end else if (accept) begin
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      ver_hlen_r  <= ver_hlen_nxt;
      total_len_r <= total_len_nxt;
      flags_off_r <= flags_off_nxt;
      ttl_r       <= ttl_nxt;
      proto_r     <= proto_nxt;
      dest_r      <= dest_nxt;
      recv_chk_r  <= recv_chk_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ihc_queue.sv -----
// ihc_queue: two-entry queue of header records between front and back
// depends on ihc_pkg
`default_nettype none

module ihc_queue
  import ihc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire hdr_rec_t  push_rec,
  input  wire logic      pop,
  output logic           full,
  output logic           q_valid,
  output hdr_rec_t       head
);

  hdr_rec_t   mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign head    = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no write into a full queue, no read from an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("header queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
    else $error("header queue underflow");
  // fill count never exceeds the depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("header queue count out of range");
`endif

endmodule

`default_nettype wire

// ----- sv/ihc_back.sv -----
// ihc_back: checks one header record, classifies it and holds the verdict
// depends on ihc_pkg and ihc_out_if
`default_nettype none

module ihc_back
  import ihc_pkg::*;
#(
  parameter int unsigned HEADER_WORDS = 5
)(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      q_valid,
  input  wire hdr_rec_t  head,
  output logic           pop,
  ihc_out_if.source      out_ch
);

  localparam logic [3:0]  HLEN_EXP  = 4'(HEADER_WORDS);
  localparam logic [15:0] HDR_BYTES = 16'(HEADER_WORDS * 4);

  logic        valid_r;
  verdict_t    verdict_r;
  err_t        err_r;
  logic [31:0] dest_r;
  logic [7:0]  ttl_out_r;
  logic [15:0] chk_out_r;
  logic [15:0] payload_r;

  verdict_t    verdict_nxt;
  err_t        err_nxt;
  logic [7:0]  ttl_out_nxt;
  logic [15:0] chk_out_nxt;
  logic [15:0] payload_nxt;
  logic [15:0] computed;
  logic [7:0]  ttl_dec;
  logic        is_local;

  assign pop = q_valid && (!valid_r || out_ch.ready);

  // checksum of the received header and of the forwarded one
  assign computed = ~fold16({2'b00, head.sum} + {2'b00, head.ttl, head.proto});
  assign ttl_dec  = head.ttl - 8'd1;
  assign is_local = (head.dest == cfg.iface_addr) || (head.dest == cfg.spf_addr);

  // header checks in cause order
  always_comb begin
    priority if (head.ver_hlen[7:4] != IPV4_VERSION) begin
      err_nxt = E_VERSION;
    end else if (head.ver_hlen[3:0] != HLEN_EXP || head.count != HLEN_EXP) begin
      err_nxt = E_HLEN;
    end else if (head.total_len < cfg.min_len || head.total_len > cfg.max_len) begin
      err_nxt = E_TOTLEN;
    end else if (computed != head.recv_chk) begin
      err_nxt = E_CHECKSUM;
    end else if (head.flags_off != FLAGS_DF && head.flags_off != FLAGS_NONE) begin
      err_nxt = E_FRAGMENT;
    end else begin
      err_nxt = E_NONE;
    end
  end

  // verdict, ttl, checksum and payload length
  always_comb begin
    ttl_out_nxt = head.ttl;
    chk_out_nxt = '0;
    payload_nxt = '0;
    verdict_nxt = V_DROP;
    if (err_nxt == E_NONE) begin
      payload_nxt = (head.total_len > HDR_BYTES) ? head.total_len - HDR_BYTES : '0;
      if (is_local) begin
        priority if (head.ttl == 8'd1)         verdict_nxt = V_LOCAL_TTL;
        else if (head.proto == PROTO_ICMP)     verdict_nxt = V_ICMP;
        else if (head.proto == PROTO_TCP)      verdict_nxt = V_TCP;
        else if (head.proto == PROTO_UDP)      verdict_nxt = V_UDP;
        else if (head.proto == PROTO_OSPF)     verdict_nxt = V_OSPF;
        else                                   verdict_nxt = V_UNREACH;
      end else if (head.ttl <= 8'd1) begin
        verdict_nxt = V_FWD_TTL;
      end else begin
        verdict_nxt = V_FORWARD;
        ttl_out_nxt = ttl_dec;
        chk_out_nxt = ~fold16({2'b00, head.sum} + {2'b00, ttl_dec, head.proto});
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict_r <= verdict_nxt;
      err_r     <= err_nxt;
      dest_r    <= head.dest;
      ttl_out_r <= ttl_out_nxt;
      chk_out_r <= chk_out_nxt;
      payload_r <= payload_nxt;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.verdict        = verdict_r;
  assign out_ch.error_cause    = err_r;
  assign out_ch.dest_addr      = dest_r;
  assign out_ch.new_ttl        = ttl_out_r;
  assign out_ch.new_checksum   = chk_out_r;
  assign out_ch.payload_length = payload_r;

`ifndef SYNTHESIS
  // a drop always carries a cause and a non-drop never does
  a_drop_cause: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((verdict_r == V_DROP) == (err_r != E_NONE)))
    else $error("verdict and error cause disagree");
  // only a forwarded header gets a new checksum and a lowered ttl
  a_chk_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && verdict_r != V_FORWARD) |-> (chk_out_r == 16'd0))
    else $error("checksum set on a non-forward verdict");
  // a popped record lands in the output register on the next edge
  a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n) pop |=> valid_r)
    else $error("popped header not presented");
`endif

endmodule

`default_nettype wire

// ----- sv/ipv4_ingress_header_classifier.sv -----
// IPv4 ingress header classifier. Takes one 32-bit header word per cycle
// (first byte in the top bits, last_word on the final word) and gives one
// verdict per header: drop with a cause, a local verdict by ttl and protocol,
// or forward with ttl lowered and the checksum recomputed. A word is taken
// every cycle the queue is not full: the front collects the running
// ones-complement sum and fields, a two-entry queue carries finished headers,
// and the back checks and classifies one header per cycle while its output
// register is free or being read, into that register, to offer the verdict.
// Input stalls only while the queue is full: a verdict held in the output
// register, two more finished headers behind it. Configuration is written
// via cfg_we/cfg_index/cfg_wdata by the user while idle; nothing enforces it.
// depends on ihc_pkg, ihc_if, ihc_front, ihc_queue and ihc_back
`default_nettype none

module ipv4_ingress_header_classifier
  import ihc_pkg::*;
#(
  parameter int unsigned HEADER_WORDS = 5
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  ihc_in_if.sink                     in_ch,
  ihc_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t     cfg_r;
  logic     q_full;
  logic     q_valid;
  logic     push;
  logic     pop;
  hdr_rec_t push_rec;
  hdr_rec_t head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.iface_addr <= 32'd0;
      cfg_r.spf_addr   <= 32'hE000_0005;
      cfg_r.min_len    <= 16'd20;
      cfg_r.max_len    <= 16'd1500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IFACE_ADDR: cfg_r.iface_addr <= cfg_wdata;
        CFG_SPF_ADDR:   cfg_r.spf_addr   <= cfg_wdata;
        CFG_MIN_LEN:    cfg_r.min_len    <= cfg_wdata[15:0];
        CFG_MAX_LEN:    cfg_r.max_len    <= cfg_wdata[15:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  // word collection
  ihc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .rec    (push_rec)
  );

  // header queue
  ihc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .head     (head)
  );

  // checks and classification
  ihc_back #(
    .HEADER_WORDS (HEADER_WORDS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// tb: self-checking bench for ipv4_ingress_header_classifier, streams directed and random
// ipv4 headers word by word and checks each verdict against a built-in header predictor
// depends on ihc_pkg, ihc_if and the classifier rtl

module tb;
  import ihc_pkg::*;

  localparam int unsigned HDR_WORDS    = 5;
  localparam logic [7:0]  VH_OK        = {IPV4_VERSION, 4'(HDR_WORDS)};
  localparam logic [15:0] HDR_BYTES    = 16'(HDR_WORDS * 4);
  localparam logic [15:0] FLAGS_MF     = 16'h2000;
  localparam logic [31:0] IFACE_A      = 32'hC0A8_0001;
  localparam logic [31:0] SPF_DEFAULT  = 32'hE000_0005;
  localparam logic [31:0] FAR_DEST     = 32'h0808_0808;
  localparam int          MAX_WORDS    = 17;
  localparam int          RAND_HEADERS = 75;
  localparam int          LONG_HOLD    = 64;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          MAX_REPORTS  = 10;

  // how the checksum field of a generated header is filled
  typedef enum int {CHK_GOOD, CHK_BAD, CHK_ZERO, CHK_ONES} chk_mode_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } hdr_word_t;

  typedef struct packed {
    verdict_t    verdict;
    err_t        cause;
    logic [31:0] dest;
    logic [7:0]  ttl;
    logic [15:0] chk;
    logic [15:0] payload;
  } verdict_rec_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ihc_in_if  in_ch ();
  ihc_out_if out_ch ();

  ipv4_ingress_header_classifier #(.HEADER_WORDS(HDR_WORDS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  hdr_word_t    word_q[$];
  verdict_rec_t verdict_q[$];

  // register copies, starting from reset values
  logic [31:0] cfg_iface = 32'h0;
  logic [31:0] cfg_spf   = SPF_DEFAULT;
  logic [15:0] cfg_min   = 16'd20;
  logic [15:0] cfg_max   = 16'd1500;

  // header being collected by the predictor
  logic [3:0]  hdr_count = '0;
  logic [15:0] hdr_sum   = '0;
  logic [7:0]  hdr_vh    = '0;
  logic [15:0] hdr_total = '0;
  logic [15:0] hdr_frag  = '0;
  logic [7:0]  hdr_ttl   = '0;
  logic [7:0]  hdr_proto = '0;
  logic [31:0] hdr_dest  = '0;
  logic [15:0] hdr_chk   = '0;

  int send_idle_pct = 31;
  int recv_idle_pct = 60;
  int holds_asked   = 0;
  int holds_served;
  int hold_left;
  int stall_cycles;
  int words_in         = 0;
  int verdicts_checked = 0;
  int mismatches       = 0;
  int drops            = 0;
  int locals           = 0;
  int forwards         = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ones-complement add of both halves of a word into a 16-bit sum
  function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [31:0] w);
    logic [17:0] s;
    s = 18'(acc) + 18'(w[31:16]) + 18'(w[15:0]);
    s = 18'(s[15:0]) + 18'(s[17:16]);
    s = 18'(s[15:0]) + 18'(s[17:16]);
    return s[15:0];
  endfunction

  // header predictor: fold one accepted word in, classify on the final word
  function automatic void absorb_word(input logic [31:0] w, input logic last);
    verdict_rec_t r;
    logic [15:0]  computed;
    if (hdr_count == POS_TTL) begin
      hdr_ttl   = w[31:24];
      hdr_proto = w[23:16];
      hdr_chk   = w[15:0];
    end else begin
      hdr_sum = ones_add(hdr_sum, w);
      if (hdr_count == POS_LEN) begin
        hdr_vh    = w[31:24];
        hdr_total = w[15:0];
      end else if (hdr_count == POS_FRAG) begin
        hdr_frag = w[15:0];
      end else if (hdr_count == POS_DEST) begin
        hdr_dest = w;
      end
    end
    if (hdr_count != COUNT_MAX) hdr_count = hdr_count + 4'd1;
    if (!last) return;

    // checks in code order, first failure names the cause
    computed = ~ones_add(hdr_sum, {16'h0, hdr_ttl, hdr_proto});
    r.cause = E_NONE;
    if (hdr_vh[7:4] != IPV4_VERSION) r.cause = E_VERSION;
    else if (hdr_vh[3:0] != 4'(HDR_WORDS) || hdr_count != 4'(HDR_WORDS)) r.cause = E_HLEN;
    else if (hdr_total < cfg_min || hdr_total > cfg_max) r.cause = E_TOTLEN;
    else if (computed != hdr_chk) r.cause = E_CHECKSUM;
    else if (hdr_frag != FLAGS_DF && hdr_frag != FLAGS_NONE) r.cause = E_FRAGMENT;

    r.dest    = hdr_dest;
    r.ttl     = hdr_ttl;
    r.chk     = '0;
    r.payload = '0;
    if (r.cause != E_NONE) begin
      r.verdict = V_DROP;
    end else begin
      r.payload = (hdr_total > HDR_BYTES) ? hdr_total - HDR_BYTES : 16'd0;
      if (hdr_dest == cfg_iface || hdr_dest == cfg_spf) begin
        if (hdr_ttl == 8'd1) begin
          r.verdict = V_LOCAL_TTL;
        end else begin
          case (hdr_proto)
            PROTO_ICMP: r.verdict = V_ICMP;
            PROTO_TCP:  r.verdict = V_TCP;
            PROTO_UDP:  r.verdict = V_UDP;
            PROTO_OSPF: r.verdict = V_OSPF;
            default:    r.verdict = V_UNREACH;
          endcase
        end
      end else if (hdr_ttl <= 8'd1) begin
        r.verdict = V_FWD_TTL;
      end else begin
        r.verdict = V_FORWARD;
        r.ttl     = hdr_ttl - 8'd1;
        r.chk     = ~ones_add(hdr_sum, {16'h0, r.ttl, hdr_proto});
      end
    end
    verdict_q.push_back(r);

    hdr_count = '0;
    hdr_sum   = '0;
    hdr_vh    = '0;
    hdr_total = '0;
    hdr_frag  = '0;
    hdr_ttl   = '0;
    hdr_proto = '0;
    hdr_dest  = '0;
    hdr_chk   = '0;
  endfunction

  function automatic string show_rec(input verdict_rec_t r);
    return $sformatf("verdict=%0d cause=%0d dest=%h ttl=%0d chk=%h payload=%0d",
                     r.verdict, r.cause, r.dest, r.ttl, r.chk, r.payload);
  endfunction

  // build one header of nwords words and queue it for the driver
  task automatic queue_header(input logic [7:0] vh, input logic [15:0] tot,
                              input logic [15:0] frag, input logic [7:0] ttl,
                              input logic [7:0] proto, input logic [31:0] dst,
                              input int nwords, input chk_mode_t mode);
    logic [31:0] w [MAX_WORDS];
    logic [15:0] acc;
    logic [15:0] chk;
    int          i;
    w[0] = {vh, 8'($urandom), tot};
    w[1] = {16'($urandom), frag};
    w[2] = {ttl, proto, 16'h0};
    w[3] = $urandom;
    w[4] = dst;
    for (i = 5; i < MAX_WORDS; i++) w[i] = $urandom;
    if (mode == CHK_ZERO || mode == CHK_ONES) w[3][15:0] = 16'h0;
    acc = ones_add(16'h0, {16'h0, ttl, proto});
    for (i = 0; i < nwords; i++) begin
      if (i != 2) acc = ones_add(acc, w[i]);
    end
    case (mode)
      // source address low half tuned so the correct checksum is zero
      CHK_ZERO, CHK_ONES: begin
        w[3][15:0] = 16'hFFFF - acc;
        chk = (mode == CHK_ZERO) ? 16'h0000 : 16'hFFFF;
      end
      CHK_BAD: chk = ~acc ^ 16'($urandom_range(16'hFFFF, 1));
      default: chk = ~acc;
    endcase
    w[2][15:0] = chk;
    for (i = 0; i < nwords; i++) word_q.push_back('{word: w[i], last: (i == nwords - 1)});
  endtask

  // mostly well-formed headers with random content, some broken ones
  task automatic queue_random_header();
    int          kind;
    int          nw;
    chk_mode_t   cm;
    logic [7:0]  vh;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [15:0] tot;
    logic [15:0] frag;
    logic [31:0] dst;
    kind = $urandom_range(99);
    vh   = VH_OK;
    nw   = HDR_WORDS;
    cm   = CHK_GOOD;
    frag = $urandom_range(1) ? FLAGS_DF : FLAGS_NONE;
    tot  = (cfg_min <= cfg_max) ? 16'($urandom_range(cfg_max, cfg_min)) : 16'($urandom);
    case ($urandom_range(3))
      0:       ttl = 8'($urandom_range(2));
      1:       ttl = 8'hFF;
      default: ttl = 8'($urandom);
    endcase
    case ($urandom_range(5))
      0:       proto = PROTO_ICMP;
      1:       proto = PROTO_TCP;
      2:       proto = PROTO_UDP;
      3:       proto = PROTO_OSPF;
      default: proto = 8'($urandom);
    endcase
    case ($urandom_range(3))
      0:       dst = cfg_iface;
      1:       dst = cfg_spf;
      default: dst = $urandom;
    endcase
    if (kind < 5) begin
      cm = $urandom_range(1) ? CHK_ZERO : CHK_ONES;
    end else if (kind >= 75) begin
      case ($urandom_range(5))
        0: vh = 8'($urandom);
        1: nw = $urandom_range(MAX_WORDS, 1);
        2: tot = 16'($urandom);
        3: cm = CHK_BAD;
        4: frag = 16'($urandom);
        default: begin
          vh   = 8'($urandom);
          nw   = $urandom_range(MAX_WORDS, 1);
          tot  = 16'($urandom);
          frag = 16'($urandom);
          cm   = $urandom_range(1) ? CHK_BAD : CHK_GOOD;
        end
      endcase
    end
    queue_header(vh, tot, frag, ttl, proto, dst, nw, cm);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IFACE_ADDR: cfg_iface = val;
      CFG_SPF_ADDR:   cfg_spf   = val;
      CFG_MIN_LEN:    cfg_min   = val[15:0];
      CFG_MAX_LEN:    cfg_max   = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] iface, input logic [31:0] spf,
                               input logic [15:0] lo, input logic [15:0] hi);
    write_reg(CFG_IFACE_ADDR, iface);
    write_reg(CFG_SPF_ADDR, spf);
    write_reg(CFG_MIN_LEN, 32'(lo));
    write_reg(CFG_MAX_LEN, 32'(hi));
  endtask

  // sender pause: everything sent and every verdict back, then let the pipe settle
  task automatic wait_drained();
    while (word_q.size() != 0 || in_ch.valid || verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // word driver
  always @(posedge clk) begin : drive_words
    hdr_word_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = word_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.header_word <= nxt.word;
        in_ch.last_word   <= nxt.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // verdict receiver with random idling and long hold-offs on request
  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_ch.ready <= 1'b0;
      hold_left    <= LONG_HOLD - 1;
      holds_served <= holds_served + 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: check each verdict transaction, then feed accepted words to the predictor
  always @(posedge clk) begin : watch_channels
    verdict_rec_t want;
    verdict_rec_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.verdict = verdict_t'(out_ch.verdict);
      got.cause   = err_t'(out_ch.error_cause);
      got.dest    = out_ch.dest_addr;
      got.ttl     = out_ch.new_ttl;
      got.chk     = out_ch.new_checksum;
      got.payload = out_ch.payload_length;
      verdicts_checked++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("verdict %0d with none expected: %s", verdicts_checked, show_rec(got));
      end else begin
        want = verdict_q.pop_front();
        case (want.verdict)
          V_DROP:              drops++;
          V_FORWARD, V_FWD_TTL: forwards++;
          default:             locals++;
        endcase
        if (got.verdict !== want.verdict || got.cause !== want.cause ||
            got.dest !== want.dest || got.ttl !== want.ttl ||
            got.chk !== want.chk || got.payload !== want.payload) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at verdict %0d: expected %s", verdicts_checked, show_rec(want));
            $display("  actual %s", show_rec(got));
          end
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      words_in++;
      absorb_word(in_ch.header_word, in_ch.last_word);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin : watchdog
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    in_ch.valid       = 1'b0;
    in_ch.header_word = '0;
    in_ch.last_word   = 1'b0;
    out_ch.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every verdict and each check failing alone
    load_settings(IFACE_A, SPF_DEFAULT, 16'd20, 16'd1500);
    queue_header(VH_OK, 16'd20, FLAGS_NONE, 8'd64, PROTO_ICMP, IFACE_A, HDR_WORDS, CHK_GOOD);
    queue_header(VH_OK, 16'd1500, FLAGS_DF, 8'd128, PROTO_TCP, IFACE_A, HDR_WORDS, CHK_GOOD);
    queue_header(VH_OK, 16'd576, FLAGS_DF, 8'd255, PROTO_UDP, SPF_DEFAULT, HDR_WORDS, CHK_GOOD);
    queue_header(VH_OK, 16'd64, FLAGS_NONE, 8'd2, PROTO_OSPF, SPF_DEFAULT, HDR_WORDS, CHK_GOOD);
    queue_header(VH_OK, 16'd40, FLAGS_DF, 8'd9, 8'd255, IFACE_A, HDR_WORDS, CHK_GOOD);
    // local ttl of one expires, zero does not
    queue_header(VH_OK, 16'd40, FLAGS_DF, 8'd1, PROTO_TCP, IFACE_A, HDR_WORDS, CHK_GOOD);
    queue_header(VH_OK, 16'd40, FLAGS_DF, 8'd0, PROTO_UDP, IFACE_A, HDR_WORDS, CHK_GOOD);
    // forwarding, lowest live ttl, expired ttls, all-ones destination
    queue_header(VH_OK, 16'd100, FLAGS_DF, 8'd2, PROTO_TCP, FAR_DEST, HDR_WORDS, CHK_GOOD);
    queue_header(VH_OK, 16'd100, FLAGS_DF, 8'd1, PROTO_TCP, FAR_DEST, HDR_WORDS, CHK_GOOD);
    queue_header(VH_OK, 16'd100, FLAGS_NONE, 8'd0, PROTO_TCP, FAR_DEST, HDR_WORDS, CHK_GOOD);
    queue_header(VH_OK, 16'd1500, FLAGS_DF, 8'd255, PROTO_UDP, 32'hFFFF_FFFF, HDR_WORDS,
                 CHK_GOOD);
    // wrong version, also on a one-word header
    queue_header(8'h65, 16'd40, FLAGS_DF, 8'd64, PROTO_TCP, FAR_DEST, HDR_WORDS, CHK_GOOD);
    queue_header(8'h60, 16'd40, FLAGS_DF, 8'd64, PROTO_TCP, FAR_DEST, 1, CHK_GOOD);
    // header length: ihl off, stream short, stream past the count ceiling
    queue_header(8'h46, 16'd40, FLAGS_DF, 8'd64, PROTO_TCP, FAR_DEST, 6, CHK_GOOD);
    queue_header(VH_OK, 16'd40, FLAGS_DF, 8'd64, PROTO_TCP, FAR_DEST, 4, CHK_GOOD);
    queue_header(VH_OK, 16'd40, FLAGS_DF, 8'd64, PROTO_TCP, FAR_DEST, MAX_WORDS, CHK_GOOD);
    // total length just outside the bounds
    queue_header(VH_OK, 16'd19, FLAGS_DF, 8'd64, PROTO_TCP, FAR_DEST, HDR_WORDS, CHK_GOOD);
    queue_header(VH_OK, 16'd1501, FLAGS_DF, 8'd64, PROTO_TCP, FAR_DEST, HDR_WORDS, CHK_GOOD);
    // checksum: corrupted, zero correct, all-ones where zero is correct
    queue_header(VH_OK, 16'd40, FLAGS_DF, 8'd64, PROTO_TCP, FAR_DEST, HDR_WORDS, CHK_BAD);
    queue_header(VH_OK, 16'd40, FLAGS_DF, 8'd64, PROTO_TCP, FAR_DEST, HDR_WORDS, CHK_ZERO);
    queue_header(VH_OK, 16'd40, FLAGS_DF, 8'd64, PROTO_TCP, FAR_DEST, HDR_WORDS, CHK_ONES);
    // fragments
    queue_header(VH_OK, 16'd40, FLAGS_MF, 8'd64, PROTO_TCP, FAR_DEST, HDR_WORDS, CHK_GOOD);
    queue_header(VH_OK, 16'd40, 16'hFFFF, 8'd64, PROTO_TCP, FAR_DEST, HDR_WORDS, CHK_GOOD);
    wait_drained();

    // directed: widest length window, extreme addresses, short total length
    load_settings(32'h0, 32'hFFFF_FFFF, 16'd0, 16'hFFFF);
    queue_header(VH_OK, 16'd0, FLAGS_DF, 8'd64, PROTO_TCP, FAR_DEST, HDR_WORDS, CHK_GOOD);
    queue_header(VH_OK, 16'hFFFF, FLAGS_DF, 8'd64, PROTO_ICMP, 32'h0, HDR_WORDS, CHK_GOOD);
    queue_header(VH_OK, 16'd60, FLAGS_NONE, 8'd1, PROTO_UDP, 32'hFFFF_FFFF, HDR_WORDS,
                 CHK_GOOD);
    wait_drained();

    // directed: crossed bounds reject every length
    load_settings(IFACE_A, SPF_DEFAULT, 16'd600, 16'd599);
    queue_header(VH_OK, 16'd600, FLAGS_DF, 8'd64, PROTO_TCP, IFACE_A, HDR_WORDS, CHK_GOOD);
    queue_header(VH_OK, 16'd599, FLAGS_DF, 8'd64, PROTO_TCP, FAR_DEST, HDR_WORDS, CHK_GOOD);
    wait_drained();

    // random: receiver idles more, one long output hold-off
    load_settings($urandom, SPF_DEFAULT, 16'd20, 16'd1500);
    holds_asked++;
    repeat (RAND_HEADERS) queue_random_header();
    wait_drained();

    // random: sender idles more, extreme register values
    send_idle_pct = 60;
    recv_idle_pct = 31;
    load_settings(32'h0, 32'hFFFF_FFFF, 16'd0, 16'hFFFF);
    repeat (RAND_HEADERS) queue_random_header();
    wait_drained();

    // random: no idling, long hold-off fills the block and backs up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_settings(32'hFFFF_FFFF, 32'h0, 16'd46, 16'd9000);
    holds_asked++;
    repeat (RAND_HEADERS) queue_random_header();
    wait_drained();

    $display("run: %0d header words, %0d verdicts (%0d dropped, %0d local, %0d forwarded)",
             words_in, verdicts_checked, drops, locals, forwards);
    $display("run: corner headers, six register settings incl. crossed bounds, output stalls");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d verdicts wrong or unexpected", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
